### sv/assert_macros.svh
// Assertion macros shared by the link frame validator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lfv_pkg.sv
// Types and constants of the link frame validator.
`timescale 1ns / 1ps

package lfv_pkg;

   localparam int unsigned FRAME_BYTES = 19;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ID_W        = 32;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   // Byte positions within a frame
   localparam logic [POS_W-1:0] POS_DEST    = 5'd0;
   localparam logic [POS_W-1:0] POS_TYPE    = 5'd1;
   localparam logic [POS_W-1:0] POS_FLAGS   = 5'd2;
   localparam logic [POS_W-1:0] POS_ID3     = 5'd3;
   localparam logic [POS_W-1:0] POS_ID2     = 5'd4;
   localparam logic [POS_W-1:0] POS_ID1     = 5'd5;
   localparam logic [POS_W-1:0] POS_ID0     = 5'd6;
   localparam logic [POS_W-1:0] POS_LENGTH  = 5'd7;
   localparam logic [POS_W-1:0] POS_SEQ     = 5'd16;
   localparam logic [POS_W-1:0] POS_CHECK   = 5'd17;
   localparam logic [POS_W-1:0] POS_LAST    = 5'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_IDLE    = 5'(FRAME_BYTES);

   localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h20;
   localparam logic [BYTE_W-1:0] MAX_LENGTH   = 8'd8;
   localparam int unsigned       STD_ID_BITS  = 11;
   localparam int unsigned       EXT_ID_BITS  = 29;

   // Verdict codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_DEST     = 3'd1;
   localparam logic [2:0] ERR_TYPE     = 3'd2;
   localparam logic [2:0] ERR_LENGTH   = 3'd3;
   localparam logic [2:0] ERR_TRAILER  = 3'd4;
   localparam logic [2:0] ERR_ID_RANGE = 3'd5;
   localparam logic [2:0] ERR_CHECKSUM = 3'd6;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_DEST_A    = 3'd0;
   localparam logic [2:0] REG_DEST_B    = 3'd1;
   localparam logic [2:0] REG_DEST_C    = 3'd2;
   localparam logic [2:0] REG_TYPE_MIN  = 3'd3;
   localparam logic [2:0] REG_TYPE_MAX  = 3'd4;
   localparam logic [2:0] REG_RESP_TYPE = 3'd5;
   localparam logic [2:0] REG_FLOW_TYPE = 3'd6;
   localparam logic [2:0] REG_EXT_MASK  = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] dest_a;
      logic [BYTE_W-1:0] dest_b;
      logic [BYTE_W-1:0] dest_c;
      logic [BYTE_W-1:0] type_min;
      logic [BYTE_W-1:0] type_max;
      logic [BYTE_W-1:0] resp_type;
      logic [BYTE_W-1:0] flow_type;
      logic [BYTE_W-1:0] ext_mask;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dest_a:    8'd0,
      dest_b:    8'd1,
      dest_c:    8'd2,
      type_min:  8'd0,
      type_max:  8'd255,
      resp_type: 8'd1,
      flow_type: 8'd2,
      ext_mask:  8'd1
   };

   typedef struct packed {
      logic [BYTE_W-1:0] dest;
      logic [BYTE_W-1:0] ftype;
      logic [BYTE_W-1:0] flags;
      logic [ID_W-1:0]   ident;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] seq_byte;
      logic [BYTE_W-1:0] chk_byte;
      logic [BYTE_W-1:0] xor_sum;
   } hold_type;

   typedef struct packed {
      logic     last_byte;
      hold_type hold;
   } trk_status_type;

   typedef struct packed {
      logic              frame_ok;
      logic [2:0]        error_code;
      logic [BYTE_W-1:0] dest_code;
      logic [BYTE_W-1:0] frame_type;
      logic [ID_W-1:0]   can_id;
      logic              extended_id;
      logic [3:0]        data_length;
      logic [BYTE_W-1:0] sequence_res;
   } result_type;

endpackage

### sv/lfv_req_if.sv
// Byte input channel of the link frame validator.
`timescale 1ns / 1ps

interface lfv_req_if;
   logic                        valid;
   logic                        ready;
   logic [lfv_pkg::BYTE_W-1:0]  data_byte;
   logic                        frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

### sv/lfv_rsp_if.sv
// Verdict output channel of the link frame validator.
`timescale 1ns / 1ps

interface lfv_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_ok;
   logic [2:0]                  error_code;
   logic [lfv_pkg::BYTE_W-1:0]  dest_code;
   logic [lfv_pkg::BYTE_W-1:0]  frame_type;
   logic [lfv_pkg::ID_W-1:0]    can_id;
   logic                        extended_id;
   logic [3:0]                  data_length;
   logic [lfv_pkg::BYTE_W-1:0]  sequence_res;

   modport source (output valid, output frame_ok, output error_code, output dest_code,
                   output frame_type, output can_id, output extended_id,
                   output data_length, output sequence_res, input ready);
   modport sink   (input valid, input frame_ok, input error_code, input dest_code,
                   input frame_type, input can_id, input extended_id,
                   input data_length, input sequence_res, output ready);
endinterface

### sv/lfv_csr.sv
// APB-style configuration registers of the link frame validator.
`timescale 1ns / 1ps

module lfv_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lfv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lfv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lfv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output lfv_pkg::cfg_type                   cfg
);

   lfv_pkg::cfg_type           cfg_ff, cfg_in;
   logic [2:0]                 reg_idx;
   logic [lfv_pkg::BYTE_W-1:0] wr_byte;
   logic [lfv_pkg::BYTE_W-1:0] rd_byte;

   assign reg_idx = paddr[lfv_pkg::CSR_ADDR_W-1:2];
   assign wr_byte = pwdata[lfv_pkg::BYTE_W-1:0];
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            lfv_pkg::REG_DEST_A:    cfg_in.dest_a    = wr_byte;
            lfv_pkg::REG_DEST_B:    cfg_in.dest_b    = wr_byte;
            lfv_pkg::REG_DEST_C:    cfg_in.dest_c    = wr_byte;
            lfv_pkg::REG_TYPE_MIN:  cfg_in.type_min  = wr_byte;
            lfv_pkg::REG_TYPE_MAX:  cfg_in.type_max  = wr_byte;
            lfv_pkg::REG_RESP_TYPE: cfg_in.resp_type = wr_byte;
            lfv_pkg::REG_FLOW_TYPE: cfg_in.flow_type = wr_byte;
            default:                cfg_in.ext_mask  = wr_byte;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         lfv_pkg::REG_DEST_A:    rd_byte = cfg_ff.dest_a;
         lfv_pkg::REG_DEST_B:    rd_byte = cfg_ff.dest_b;
         lfv_pkg::REG_DEST_C:    rd_byte = cfg_ff.dest_c;
         lfv_pkg::REG_TYPE_MIN:  rd_byte = cfg_ff.type_min;
         lfv_pkg::REG_TYPE_MAX:  rd_byte = cfg_ff.type_max;
         lfv_pkg::REG_RESP_TYPE: rd_byte = cfg_ff.resp_type;
         lfv_pkg::REG_FLOW_TYPE: rd_byte = cfg_ff.flow_type;
         default:                rd_byte = cfg_ff.ext_mask;
      endcase
   end

   assign prdata = {{(lfv_pkg::CSR_DATA_W - lfv_pkg::BYTE_W){1'b0}}, rd_byte};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lfv_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/lfv_tracker.sv
// Byte position counter, running XOR and held header fields of a frame.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfv_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [lfv_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          frame_start,
   output lfv_pkg::trk_status_type       status
);

   logic [lfv_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [lfv_pkg::POS_W-1:0] pos_cur;
   logic                      active;
   logic [lfv_pkg::BYTE_W-1:0] xor_base;
   lfv_pkg::hold_type         hold_ff, hold_in;

   // A start byte always opens a new frame, aborting any frame in progress
   assign pos_cur  = frame_start ? lfv_pkg::POS_DEST : pos_ff;
   assign active   = frame_start || (pos_ff < lfv_pkg::POS_IDLE);
   assign xor_base = frame_start ? '0 : hold_ff.xor_sum;

   always_comb begin
      pos_in  = pos_ff;
      hold_in = hold_ff;
      if (accept && active) begin
         pos_in = pos_cur + 5'd1;
         if (pos_cur < lfv_pkg::POS_CHECK) begin
            hold_in.xor_sum = xor_base ^ data_byte;
         end
         unique case (pos_cur)
            lfv_pkg::POS_DEST:   hold_in.dest        = data_byte;
            lfv_pkg::POS_TYPE:   hold_in.ftype       = data_byte;
            lfv_pkg::POS_FLAGS:  hold_in.flags       = data_byte;
            lfv_pkg::POS_ID3:    hold_in.ident[31:24] = data_byte;
            lfv_pkg::POS_ID2:    hold_in.ident[23:16] = data_byte;
            lfv_pkg::POS_ID1:    hold_in.ident[15:8]  = data_byte;
            lfv_pkg::POS_ID0:    hold_in.ident[7:0]   = data_byte;
            lfv_pkg::POS_LENGTH: hold_in.length      = data_byte;
            lfv_pkg::POS_SEQ:    hold_in.seq_byte    = data_byte;
            lfv_pkg::POS_CHECK:  hold_in.chk_byte    = data_byte;
            default: begin
            end
         endcase
      end
   end

   assign status.last_byte = active && (pos_cur == lfv_pkg::POS_LAST);
   assign status.hold      = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= lfv_pkg::POS_IDLE;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Held fields are all rewritten before any verdict reads them
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   `ASSERT_ALWAYS(a_pos_bound, clock, reset, pos_ff <= lfv_pkg::POS_IDLE, "byte position out of range")
   `ASSERT_NEXT(a_start_pos, clock, reset, accept && frame_start, pos_ff == 5'd1, "start byte did not open frame")

endmodule

### sv/lfv_judge.sv
// Frame checks in priority order and the verdict output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfv_judge (
   input  logic                          clock,
   input  logic                          reset,
   input  lfv_pkg::cfg_type              cfg,
   input  lfv_pkg::hold_type             hold,
   input  logic [lfv_pkg::BYTE_W-1:0]    trailer,
   input  logic                          take,
   output logic                          slot_free,
   lfv_rsp_if.source                     rsp
);

   logic                   dest_bad;
   logic                   type_bad;
   logic                   length_bad;
   logic                   trailer_bad;
   logic                   id_checked;
   logic                   ext_id;
   logic                   id_bad;
   logic                   sum_bad;
   logic [2:0]             err;
   lfv_pkg::result_type    result_ff, result_in;
   logic                   valid_ff, valid_in;

   assign dest_bad    = (hold.dest != cfg.dest_a) && (hold.dest != cfg.dest_b) &&
                        (hold.dest != cfg.dest_c);
   assign type_bad    = (hold.ftype < cfg.type_min) || (hold.ftype > cfg.type_max);
   assign length_bad  = hold.length > lfv_pkg::MAX_LENGTH;
   assign trailer_bad = trailer != lfv_pkg::TRAILER_BYTE;
   assign id_checked  = (hold.ftype == cfg.type_min) || (hold.ftype == cfg.resp_type) ||
                        (hold.ftype == cfg.flow_type);
   assign ext_id      = (hold.flags & cfg.ext_mask) != '0;
   // Id exceeds its limit when any bit above the allowed width is set
   assign id_bad      = ext_id ? (hold.ident[lfv_pkg::ID_W-1:lfv_pkg::EXT_ID_BITS] != '0)
                               : (hold.ident[lfv_pkg::ID_W-1:lfv_pkg::STD_ID_BITS] != '0);
   assign sum_bad     = hold.xor_sum != hold.chk_byte;

   always_comb begin
      priority if (dest_bad) begin
         err = lfv_pkg::ERR_DEST;
      end else if (type_bad) begin
         err = lfv_pkg::ERR_TYPE;
      end else if (length_bad) begin
         err = lfv_pkg::ERR_LENGTH;
      end else if (trailer_bad) begin
         err = lfv_pkg::ERR_TRAILER;
      end else if (id_checked && id_bad) begin
         err = lfv_pkg::ERR_ID_RANGE;
      end else if (sum_bad) begin
         err = lfv_pkg::ERR_CHECKSUM;
      end else begin
         err = lfv_pkg::ERR_NONE;
      end
   end

   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      result_in = result_ff;
      valid_in  = valid_ff;
      if (take) begin
         valid_in               = 1'b1;
         result_in.frame_ok     = err == lfv_pkg::ERR_NONE;
         result_in.error_code   = err;
         result_in.dest_code    = hold.dest;
         result_in.frame_type   = hold.ftype;
         result_in.can_id       = hold.ident;
         result_in.extended_id  = ext_id;
         result_in.data_length  = length_bad ? lfv_pkg::MAX_LENGTH[3:0] : hold.length[3:0];
         result_in.sequence_res = hold.seq_byte;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.frame_ok     = result_ff.frame_ok;
   assign rsp.error_code   = result_ff.error_code;
   assign rsp.dest_code    = result_ff.dest_code;
   assign rsp.frame_type   = result_ff.frame_type;
   assign rsp.can_id       = result_ff.can_id;
   assign rsp.extended_id  = result_ff.extended_id;
   assign rsp.data_length  = result_ff.data_length;
   assign rsp.sequence_res = result_ff.sequence_res;

   `ASSERT_ALWAYS(a_take_free, clock, reset, !take || slot_free, "verdict overwrote pending result")
   `ASSERT_NEXT(a_take_shows, clock, reset, take, valid_ff, "verdict not presented")
   `ASSERT_ALWAYS(a_ok_code, clock, reset, !valid_ff || (result_ff.frame_ok == (result_ff.error_code == lfv_pkg::ERR_NONE)), "frame_ok disagrees with error_code")
   `ASSERT_ALWAYS(a_len_clamp, clock, reset, !valid_ff || (result_ff.data_length <= 4'd8), "length not clamped")

endmodule

### sv/link_frame_validator.sv
// Top level of the link frame validator.
// Latency: the verdict is valid in the cycle after the transfer of byte 18 of a frame.
// Throughput: one byte per cycle; bytes that end no frame are taken while a verdict waits.
// The last byte of a frame waits only while the single verdict register is still full.
// Reset: byte position goes idle (no frame open), no verdict pending, registers take
// their reset values; no clearing pass.
`timescale 1ns / 1ps

module link_frame_validator (
   input  logic                               clock,
   input  logic                               reset,
   lfv_req_if.sink                            req,
   lfv_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lfv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lfv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lfv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   lfv_pkg::cfg_type        cfg;
   lfv_pkg::trk_status_type status;
   logic                    slot_free;
   logic                    accept;
   logic                    take;

   // Stall only the byte that ends a frame, and only while the verdict slot is full
   assign req.ready = slot_free || !status.last_byte;
   assign accept    = req.valid && req.ready;
   assign take      = accept && status.last_byte;

   lfv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lfv_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req.data_byte),
      .frame_start (req.frame_start),
      .status      (status)
   );

   lfv_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .hold      (status.hold),
      .trailer   (req.data_byte),
      .take      (take),
      .slot_free (slot_free),
      .rsp       (rsp)
   );

endmodule

### tb/tb_link_frame_validator.sv
// Self-checking testbench of the link frame validator: directed and random frames.
`timescale 1ns / 1ps

module tb_link_frame_validator;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned FRAME_ITEMS = 480;
   localparam int unsigned PHASES      = 7;

   // Predicts the verdict of every frame and checks what the block returns.
   class frame_verdict_board;
      localparam int unsigned SHOWN = 60;

      lfv_pkg::cfg_type            cfg;
      lfv_pkg::hold_type           held;
      logic [lfv_pkg::POS_W-1:0]   pos;
      lfv_pkg::result_type         due_verdicts[$];
      int unsigned                 mismatches;
      int unsigned                 verdicts_seen;
      int unsigned                 code_hits[8];

      function new();
         cfg  = lfv_pkg::CFG_RESET;
         held = '0;
         pos  = lfv_pkg::POS_IDLE;
      endfunction

      function void set_register(logic [2:0] idx, logic [lfv_pkg::BYTE_W-1:0] val);
         case (idx)
            lfv_pkg::REG_DEST_A:    cfg.dest_a    = val;
            lfv_pkg::REG_DEST_B:    cfg.dest_b    = val;
            lfv_pkg::REG_DEST_C:    cfg.dest_c    = val;
            lfv_pkg::REG_TYPE_MIN:  cfg.type_min  = val;
            lfv_pkg::REG_TYPE_MAX:  cfg.type_max  = val;
            lfv_pkg::REG_RESP_TYPE: cfg.resp_type = val;
            lfv_pkg::REG_FLOW_TYPE: cfg.flow_type = val;
            lfv_pkg::REG_EXT_MASK:  cfg.ext_mask  = val;
            default: ;
         endcase
      endfunction

      // First failing check wins.
      function logic [2:0] grade(logic [lfv_pkg::BYTE_W-1:0] trailer);
         logic [lfv_pkg::ID_W-1:0] limit;
         if (held.dest != cfg.dest_a && held.dest != cfg.dest_b && held.dest != cfg.dest_c)
            return lfv_pkg::ERR_DEST;
         if (held.ftype < cfg.type_min || held.ftype > cfg.type_max)
            return lfv_pkg::ERR_TYPE;
         if (held.length > lfv_pkg::MAX_LENGTH)
            return lfv_pkg::ERR_LENGTH;
         if (trailer != lfv_pkg::TRAILER_BYTE)
            return lfv_pkg::ERR_TRAILER;
         if (held.ftype == cfg.type_min || held.ftype == cfg.resp_type ||
             held.ftype == cfg.flow_type) begin
            limit = (|(held.flags & cfg.ext_mask))
                  ? {lfv_pkg::ID_W{1'b1}} >> (lfv_pkg::ID_W - lfv_pkg::EXT_ID_BITS)
                  : {lfv_pkg::ID_W{1'b1}} >> (lfv_pkg::ID_W - lfv_pkg::STD_ID_BITS);
            if (held.ident > limit)
               return lfv_pkg::ERR_ID_RANGE;
         end
         if (held.xor_sum != held.chk_byte)
            return lfv_pkg::ERR_CHECKSUM;
         return lfv_pkg::ERR_NONE;
      endfunction

      function void absorb_byte(logic [lfv_pkg::BYTE_W-1:0] b, logic start);
         lfv_pkg::result_type r;
         if (start) begin
            pos          = lfv_pkg::POS_DEST;
            held.xor_sum = '0;
         end
         if (pos >= lfv_pkg::POS_IDLE)
            return;
         if (pos < lfv_pkg::POS_CHECK)
            held.xor_sum ^= b;
         case (pos)
            lfv_pkg::POS_DEST:   held.dest          = b;
            lfv_pkg::POS_TYPE:   held.ftype         = b;
            lfv_pkg::POS_FLAGS:  held.flags         = b;
            lfv_pkg::POS_ID3:    held.ident[31:24]  = b;
            lfv_pkg::POS_ID2:    held.ident[23:16]  = b;
            lfv_pkg::POS_ID1:    held.ident[15:8]   = b;
            lfv_pkg::POS_ID0:    held.ident[7:0]    = b;
            lfv_pkg::POS_LENGTH: held.length        = b;
            lfv_pkg::POS_SEQ:    held.seq_byte      = b;
            lfv_pkg::POS_CHECK:  held.chk_byte      = b;
            default: ;
         endcase
         if (pos == lfv_pkg::POS_LAST) begin
            r.error_code   = grade(b);
            r.frame_ok     = (r.error_code == lfv_pkg::ERR_NONE);
            r.dest_code    = held.dest;
            r.frame_type   = held.ftype;
            r.can_id       = held.ident;
            r.extended_id  = |(held.flags & cfg.ext_mask);
            r.data_length  = (held.length > lfv_pkg::MAX_LENGTH) ? 4'(lfv_pkg::MAX_LENGTH)
                                                                 : held.length[3:0];
            r.sequence_res = held.seq_byte;
            due_verdicts.push_back(r);
         end
         pos = pos + 1'b1;
      endfunction

      task report(string msg);
         mismatches++;
         // limit log noise on a badly broken block
         if (mismatches <= SHOWN)
            $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_field(string field, logic [lfv_pkg::ID_W-1:0] got,
                       logic [lfv_pkg::ID_W-1:0] want);
         if (got !== want)
            report($sformatf("verdict %0d %s got 'h%0h want 'h%0h",
                             verdicts_seen, field, got, want));
      endtask

      task match_verdict(lfv_pkg::result_type got);
         lfv_pkg::result_type want;
         verdicts_seen++;
         if (due_verdicts.size() == 0) begin
            report($sformatf("verdict %0d arrived with none pending (code %0d)",
                             verdicts_seen, got.error_code));
            return;
         end
         want = due_verdicts.pop_front();
         code_hits[want.error_code]++;
         check_field("frame_ok",     got.frame_ok,     want.frame_ok);
         check_field("error_code",   got.error_code,   want.error_code);
         check_field("dest_code",    got.dest_code,    want.dest_code);
         check_field("frame_type",   got.frame_type,   want.frame_type);
         check_field("can_id",       got.can_id,       want.can_id);
         check_field("extended_id",  got.extended_id,  want.extended_id);
         check_field("data_length",  got.data_length,  want.data_length);
         check_field("sequence_res", got.sequence_res, want.sequence_res);
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [lfv_pkg::CSR_ADDR_W-1:0] paddr;
   logic [lfv_pkg::CSR_DATA_W-1:0] pwdata;
   logic [lfv_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   lfv_req_if req_ch ();
   lfv_rsp_if rsp_ch ();

   link_frame_validator DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   frame_verdict_board board = new();
   bit                 calm_tx;
   bit                 calm_rx;
   int unsigned        frame_bytes_sent;
   int unsigned        settings_applied;
   int unsigned        cycle_count;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Hold valid until the transfer; note the byte once taken.
   task automatic send_byte(logic [lfv_pkg::BYTE_W-1:0] b, logic start);
      int unsigned gap;
      gap = calm_tx ? 0 : $urandom_range(19);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.frame_start <= start;
      do @(posedge clock); while (!req_ch.ready);
      board.absorb_byte(b, start);
   endtask

   task automatic send_frame(logic [lfv_pkg::BYTE_W-1:0] dest,
                             logic [lfv_pkg::BYTE_W-1:0] ftype,
                             logic [lfv_pkg::BYTE_W-1:0] flags,
                             logic [lfv_pkg::ID_W-1:0]   ident,
                             logic [lfv_pkg::BYTE_W-1:0] length,
                             logic [lfv_pkg::BYTE_W-1:0] trailer,
                             bit bad_chk, int unsigned nbytes);
      logic [lfv_pkg::BYTE_W-1:0] fb [lfv_pkg::FRAME_BYTES];
      logic [lfv_pkg::BYTE_W-1:0] sum;
      fb[lfv_pkg::POS_DEST]   = dest;
      fb[lfv_pkg::POS_TYPE]   = ftype;
      fb[lfv_pkg::POS_FLAGS]  = flags;
      fb[lfv_pkg::POS_ID3]    = ident[31:24];
      fb[lfv_pkg::POS_ID2]    = ident[23:16];
      fb[lfv_pkg::POS_ID1]    = ident[15:8];
      fb[lfv_pkg::POS_ID0]    = ident[7:0];
      fb[lfv_pkg::POS_LENGTH] = length;
      for (int i = lfv_pkg::POS_LENGTH + 1; i <= lfv_pkg::POS_SEQ; i++)
         fb[i] = 8'($urandom);
      sum = '0;
      for (int i = 0; i < lfv_pkg::POS_CHECK; i++)
         sum ^= fb[i];
      fb[lfv_pkg::POS_CHECK] = bad_chk ? sum ^ 8'($urandom_range(255, 1)) : sum;
      fb[lfv_pkg::POS_LAST]  = trailer;
      for (int i = 0; i < nbytes; i++) begin
         send_byte(fb[i], i == 0);
         frame_bytes_sent++;
      end
   endtask

   // Write one register, then read it back.
   task automatic write_reg(logic [2:0] idx, logic [lfv_pkg::BYTE_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= lfv_pkg::CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= lfv_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[lfv_pkg::BYTE_W-1:0] !== val)
         board.report($sformatf("register %0d read 'h%0h want 'h%0h", idx, prdata, val));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      board.set_register(idx, val);
   endtask

   task automatic apply_setting(lfv_pkg::cfg_type c);
      write_reg(lfv_pkg::REG_DEST_A,    c.dest_a);
      write_reg(lfv_pkg::REG_DEST_B,    c.dest_b);
      write_reg(lfv_pkg::REG_DEST_C,    c.dest_c);
      write_reg(lfv_pkg::REG_TYPE_MIN,  c.type_min);
      write_reg(lfv_pkg::REG_TYPE_MAX,  c.type_max);
      write_reg(lfv_pkg::REG_RESP_TYPE, c.resp_type);
      write_reg(lfv_pkg::REG_FLOW_TYPE, c.flow_type);
      write_reg(lfv_pkg::REG_EXT_MASK,  c.ext_mask);
      settings_applied++;
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.due_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // Close any open frame and let the block go idle.
   task automatic quiesce();
      while (board.pos < lfv_pkg::POS_IDLE)
         send_byte(8'($urandom), 1'b0);
      drain_verdicts();
      repeat (4) @(posedge clock);
   endtask

   function automatic lfv_pkg::cfg_type phase_setting(int unsigned ph);
      lfv_pkg::cfg_type c;
      c = lfv_pkg::cfg_type'({$urandom, $urandom});
      case (ph)
         0: c = lfv_pkg::CFG_RESET;
         1: c = '0;
         2: c = '1;
         3: begin
            if (c.type_min > c.type_max)
               {c.type_min, c.type_max} = {c.type_max, c.type_min};
         end
         4: begin
            // empty type range
            c.type_min = 8'($urandom_range(255, 1));
            c.type_max = 8'($urandom_range(c.type_min - 1));
         end
         6: begin
            c.type_min = 8'h00;
            c.type_max = 8'hFF;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic random_sequence();
      logic [lfv_pkg::BYTE_W-1:0] dest;
      logic [lfv_pkg::BYTE_W-1:0] ftype;
      logic [lfv_pkg::BYTE_W-1:0] length;
      logic [lfv_pkg::BYTE_W-1:0] trailer;
      logic [lfv_pkg::ID_W-1:0]   ident;
      calm_tx = ($urandom_range(5) == 0);
      calm_rx = ($urandom_range(5) == 0);
      // stray bytes between frames
      if (board.pos >= lfv_pkg::POS_IDLE && $urandom_range(9) == 0)
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
      case ($urandom_range(9))
         0, 1, 2: dest = board.cfg.dest_a;
         3, 4, 5: dest = board.cfg.dest_b;
         6, 7:    dest = board.cfg.dest_c;
         default: dest = 8'($urandom);
      endcase
      case ($urandom_range(7))
         0:       ftype = board.cfg.type_min;
         1:       ftype = board.cfg.type_max;
         2:       ftype = board.cfg.resp_type;
         3:       ftype = board.cfg.flow_type;
         4:       ftype = board.cfg.type_min - 8'd1;
         5:       ftype = board.cfg.type_max + 8'd1;
         default: ftype = 8'($urandom);
      endcase
      case ($urandom_range(5))
         0:       ident = $urandom_range(32'h7FF);
         1:       ident = $urandom_range(32'h800, 32'h7FF);
         2:       ident = $urandom_range(32'h2000_0000, 32'h1FFF_FFFF);
         3:       ident = $urandom_range(32'h1FFF_FFFF);
         4:       ident = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: ident = $urandom;
      endcase
      length  = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 9))
                                         : 8'($urandom_range(8));
      trailer = ($urandom_range(9) == 0) ? 8'($urandom) : lfv_pkg::TRAILER_BYTE;
      send_frame(dest, ftype, 8'($urandom), ident, length, trailer, $urandom_range(9) == 0,
                 ($urandom_range(11) == 0) ? $urandom_range(lfv_pkg::POS_LAST, 1)
                                           : lfv_pkg::FRAME_BYTES);
   endtask

   task automatic directed_checks();
      lfv_pkg::cfg_type c;
      logic [lfv_pkg::BYTE_W-1:0] tr;
      int unsigned                nb;
      tr = lfv_pkg::TRAILER_BYTE;
      nb = lfv_pkg::FRAME_BYTES;
      // reset setting: dests 0/1/2, full type range, ext mask bit 0
      send_frame(8'd2,  8'd5,  8'h00, 32'h1234_5678, 8'd8,  tr,    0, nb);
      send_frame(8'hFF, 8'd5,  8'h00, 32'h0,         8'd3,  tr,    0, nb);
      send_frame(8'd0,  8'hFF, 8'hFF, 32'h0,         8'd9,  tr,    0, nb);
      send_frame(8'd1,  8'h00, 8'h00, 32'h0,         8'hFF, tr,    0, nb);
      send_frame(8'd1,  8'd7,  8'h00, 32'h0,         8'd0,  8'h21, 0, nb);
      send_frame(8'd1,  8'd1,  8'h00, 32'h7FF,       8'd0,  tr,    0, nb);
      send_frame(8'd1,  8'd1,  8'h00, 32'h800,       8'd0,  tr,    0, nb);
      send_frame(8'd0,  8'd2,  8'h01, 32'h1FFF_FFFF, 8'd4,  tr,    0, nb);
      send_frame(8'd0,  8'd2,  8'h01, 32'h2000_0000, 8'd4,  tr,    0, nb);
      send_frame(8'd2,  8'd0,  8'hFE, 32'hFFFF_FFFF, 8'd1,  tr,    0, nb);
      send_frame(8'd2,  8'd9,  8'h00, 32'h0,         8'd2,  tr,    1, nb);
      // bytes while idle are dropped
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // a start in mid-frame drops the frame in progress
      send_frame(8'd0,  8'd9,  8'h00, 32'h0,         8'd2,  tr,    0, 10);
      send_frame(8'd0,  8'd9,  8'h00, 32'h0,         8'd2,  tr,    0, nb);
      quiesce();
      c = '{dest_a: 8'hAA, dest_b: 8'h55, dest_c: 8'hFF, type_min: 8'h10, type_max: 8'h20,
            resp_type: 8'h18, flow_type: 8'h20, ext_mask: 8'h80};
      apply_setting(c);
      send_frame(8'hAA, 8'h0F, 8'h00, 32'h0,         8'd0,  tr,    0, nb);
      send_frame(8'h55, 8'h21, 8'h00, 32'h0,         8'd0,  tr,    0, nb);
      send_frame(8'hFF, 8'h10, 8'h80, 32'h1FFF_FFFF, 8'd8,  tr,    0, nb);
      send_frame(8'hFF, 8'h15, 8'h00, 32'hFFFF_FFFF, 8'd8,  tr,    0, nb);
      quiesce();
      c.type_min = 8'h81;
      c.type_max = 8'h80;
      apply_setting(c);
      send_frame(8'hAA, 8'h80, 8'h00, 32'h0,         8'd0,  tr,    0, nb);
      send_frame(8'hAA, 8'h81, 8'h00, 32'h0,         8'd0,  tr,    0, nb);
      quiesce();
   endtask

   initial begin : verdict_sink
      int unsigned         stall;
      lfv_pkg::result_type got;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = calm_rx ? 0 : $urandom_range(19);
         if (stall != 0) begin
            // hold off a verdict that is already waiting
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (!rsp_ch.valid);
            repeat (stall - 1) @(posedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.frame_ok     = rsp_ch.frame_ok;
         got.error_code   = rsp_ch.error_code;
         got.dest_code    = rsp_ch.dest_code;
         got.frame_type   = rsp_ch.frame_type;
         got.can_id       = rsp_ch.can_id;
         got.extended_id  = rsp_ch.extended_id;
         got.data_length  = rsp_ch.data_length;
         got.sequence_res = rsp_ch.sequence_res;
         board.match_verdict(got);
      end
   end

   initial begin : byte_source
      int unsigned target;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.frame_start = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_checks();
      frame_bytes_sent = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_setting(phase_setting(ph));
         for (int half = 0; half < 2; half++) begin
            target = (FRAME_ITEMS * (2 * ph + half + 1)) / (2 * PHASES);
            while (frame_bytes_sent < target)
               random_sequence();
            // mid-phase pause until every pending verdict is back
            if (ph == 2 && half == 0)
               drain_verdicts();
         end
         quiesce();
      end

      drain_verdicts();
      repeat (10) @(posedge clock);
      $display("covered %0d random frame bytes over %0d register settings, %0d verdicts checked",
               frame_bytes_sent, settings_applied, board.verdicts_seen);
      $display("verdicts by code: ok %0d dest %0d type %0d length %0d trailer %0d id %0d sum %0d",
               board.code_hits[lfv_pkg::ERR_NONE], board.code_hits[lfv_pkg::ERR_DEST],
               board.code_hits[lfv_pkg::ERR_TYPE], board.code_hits[lfv_pkg::ERR_LENGTH],
               board.code_hits[lfv_pkg::ERR_TRAILER], board.code_hits[lfv_pkg::ERR_ID_RANGE],
               board.code_hits[lfv_pkg::ERR_CHECKSUM]);
      if (board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
